>>> hdl/aerd_pkg.sv
// shared types, codes and constants of the address-event word decoder
package aerd_pkg;

   localparam int ARRAY_WIDTH  = 128;
   localparam int ARRAY_HEIGHT = 128;

   localparam int COORD_W  = 7;
   localparam int COUNT_W  = 16;
   localparam int TIME_W   = 31;
   localparam int TICK_W   = 14;
   localparam int OFFSET_W = TIME_W - TICK_W;

   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 112;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 31;

   localparam logic [CSR_INDEX_W-1:0] CSR_CONTAINER_MAX_EVENTS   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CONTAINER_MAX_INTERVAL = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_MAX_EVENTS       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_MAX_INTERVAL     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPECIAL_MAX_EVENTS     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPECIAL_MAX_INTERVAL   = 3'd5;

   localparam logic [COUNT_W-1:0] RST_CONTAINER_MAX_EVENTS   = 16'd4224;
   localparam logic [TIME_W-1:0]  RST_CONTAINER_MAX_INTERVAL = 31'd5000;
   localparam logic [COUNT_W-1:0] RST_PIXEL_MAX_EVENTS       = 16'd4096;
   localparam logic [TIME_W-1:0]  RST_PIXEL_MAX_INTERVAL     = 31'd5000;
   localparam logic [COUNT_W-1:0] RST_SPECIAL_MAX_EVENTS     = 16'd128;
   localparam logic [TIME_W-1:0]  RST_SPECIAL_MAX_INTERVAL   = 31'd1000;

   localparam logic [TIME_W-1:0]  TIME_ALL_ONES  = {TIME_W{1'b1}};
   localparam logic [COUNT_W-1:0] COUNT_ALL_ONES = {COUNT_W{1'b1}};

   typedef enum logic [2:0] {
      KIND_NONE    = 3'd0,
      KIND_PIXEL   = 3'd1,
      KIND_TRIGGER = 3'd2,
      KIND_WRAP    = 3'd3,
      KIND_RESET   = 3'd4
   } event_kind_type;

   typedef struct packed {
      logic [COUNT_W-1:0] container_max_events;
      logic [TIME_W-1:0]  container_max_interval;
      logic [COUNT_W-1:0] pixel_max_events;
      logic [TIME_W-1:0]  pixel_max_interval;
      logic [COUNT_W-1:0] special_max_events;
      logic [TIME_W-1:0]  special_max_interval;
   } config_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] wrap_offset;
      logic [TIME_W-1:0]   epoch_count;
      logic [TIME_W-1:0]   current_time;
      logic [TIME_W-1:0]   previous_time;
      logic [COUNT_W-1:0]  pixel_count;
      logic [COUNT_W-1:0]  special_count;
      logic [TIME_W-1:0]   pixel_first_time;
      logic [TIME_W-1:0]   pixel_last_time;
      logic [TIME_W-1:0]   special_first_time;
      logic [TIME_W-1:0]   special_last_time;
   } state_type;

   typedef struct packed {
      event_kind_type     event_kind;
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
      logic               pixel_on;
      logic [TIME_W-1:0]  event_time;
      logic [TIME_W-1:0]  epoch;
      logic               commit;
      logic [COUNT_W-1:0] pixel_committed;
      logic [COUNT_W-1:0] special_committed;
      logic               time_backwards;
   } result_type;

endpackage

>>> hdl/aer_event_word_decoder.sv
// top level of the address-event word decoder: word registers, state and settings
//
// Takes one 32-bit camera event word per cycle while the output is not stalled
// and returns exactly one result word for each. A word is captured in an input
// register, decoded and checked against the packet thresholds in one pass, and
// lands in the result register; the timestamp and packet state are updated
// between consecutive words. The input side keeps accepting while a result
// waits, as long as the input register is free or moving on. Threshold
// registers take effect on the next word decoded.
module aer_event_word_decoder import aerd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_tvalid,
   output logic                   req_tready,
   // address_word, time_word
   input  logic [REQ_DATA_W-1:0]  req_tdata,

   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // pixel_x, pixel_y, pixel_on, event_time, epoch, pixel_committed,
   // special_committed, time_backwards, zero pad
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // event_kind
   output logic [2:0]             rsp_tuser,
   // commit
   output logic                   rsp_tlast,

   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic        in_valid_ff;
   logic        in_valid_in;
   logic [15:0] in_address_ff;
   logic [15:0] in_time_ff;
   logic        out_valid_ff;
   logic        out_valid_in;
   result_type  result_ff;
   result_type  result_in;
   state_type   state_ff;
   state_type   state_in;
   config_type  cfg_ff;
   config_type  cfg_in;
   logic        fire;

   assign fire        = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || fire;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !fire);
   assign out_valid_in = fire || (out_valid_ff && !rsp_tready);

   aerd_step u_step (
      .address_word (in_address_ff),
      .time_word    (in_time_ff),
      .state        (state_ff),
      .cfg          (cfg_ff),
      .state_next   (state_in),
      .result       (result_in)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_CONTAINER_MAX_EVENTS:   cfg_in.container_max_events   = csr_wdata[COUNT_W-1:0];
            CSR_CONTAINER_MAX_INTERVAL: cfg_in.container_max_interval = csr_wdata;
            CSR_PIXEL_MAX_EVENTS:       cfg_in.pixel_max_events       = csr_wdata[COUNT_W-1:0];
            CSR_PIXEL_MAX_INTERVAL:     cfg_in.pixel_max_interval     = csr_wdata;
            CSR_SPECIAL_MAX_EVENTS:     cfg_in.special_max_events     = csr_wdata[COUNT_W-1:0];
            CSR_SPECIAL_MAX_INTERVAL:   cfg_in.special_max_interval   = csr_wdata;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.container_max_events   <= RST_CONTAINER_MAX_EVENTS;
         cfg_ff.container_max_interval <= RST_CONTAINER_MAX_INTERVAL;
         cfg_ff.pixel_max_events       <= RST_PIXEL_MAX_EVENTS;
         cfg_ff.pixel_max_interval     <= RST_PIXEL_MAX_INTERVAL;
         cfg_ff.special_max_events     <= RST_SPECIAL_MAX_EVENTS;
         cfg_ff.special_max_interval   <= RST_SPECIAL_MAX_INTERVAL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_address_ff <= req_tdata[15:0];
         in_time_ff    <= req_tdata[31:16];
      end
      if (fire) begin
         result_ff <= result_in;
      end
   end

   // packet first and last times are only read once written
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.wrap_offset   <= '0;
         state_ff.epoch_count   <= '0;
         state_ff.current_time  <= '0;
         state_ff.previous_time <= '0;
         state_ff.pixel_count   <= '0;
         state_ff.special_count <= '0;
      end else if (fire) begin
         state_ff <= state_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = result_ff.event_kind;
   assign rsp_tlast  = result_ff.commit;
   assign rsp_tdata  = {2'b00,
                        result_ff.time_backwards,
                        result_ff.special_committed,
                        result_ff.pixel_committed,
                        result_ff.epoch,
                        result_ff.event_time,
                        result_ff.pixel_on,
                        result_ff.pixel_y,
                        result_ff.pixel_x};

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_WRAP || rsp_tuser == KIND_RESET) |-> rsp_tlast)
      else $error("wrap or reset word without commit");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[108:77] == '0)
      else $error("committed counts without commit");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_RESET |-> rsp_tdata[76:46] == '0)
      else $error("epoch not cleared by timestamp reset");

   assert property (@(posedge clock) disable iff (reset)
      fire && result_in.commit |=> state_ff.pixel_count == '0 && state_ff.special_count == '0)
      else $error("packet counts not cleared after commit");

endmodule

>>> hdl/aerd_step.sv
// decode of one event word, timestamp expansion and packet commit check
module aerd_step import aerd_pkg::*; (
   input  logic [15:0] address_word,
   input  logic [15:0] time_word,
   input  state_type   state,
   input  config_type  cfg,
   output state_type   state_next,
   output result_type  result
);

   logic                  forced;
   logic                  do_check;
   logic                  add_pixel;
   logic                  add_special;
   logic [TIME_W-1:0]     stamp;
   logic [OFFSET_W-1:0]   offset_inc;
   logic [COORD_W-1:0]    raw_x;
   logic [COORD_W-1:0]    row_y;
   logic signed [TIME_W:0]   pixel_span;
   logic signed [TIME_W:0]   special_span;
   logic signed [TIME_W+1:0] span_sum;
   logic [COUNT_W:0]      count_sum;
   logic                  container_hit;
   logic                  pixel_hit;
   logic                  special_hit;

   assign offset_inc = state.wrap_offset + OFFSET_W'(1);
   assign raw_x      = address_word[7:1];
   assign row_y      = address_word[14:8];

   always_comb begin
      state_next    = state;
      result        = '0;
      result.event_kind = KIND_NONE;
      forced        = 1'b0;
      do_check      = 1'b1;
      add_pixel     = 1'b0;
      add_special   = 1'b0;
      stamp         = '0;
      pixel_span    = '0;
      special_span  = '0;
      span_sum      = '0;
      count_sum     = '0;
      container_hit = 1'b0;
      pixel_hit     = 1'b0;
      special_hit   = 1'b0;

      if (time_word[15]) begin
         if (&state.wrap_offset) begin
            state_next.wrap_offset   = '0;
            state_next.previous_time = '0;
            state_next.current_time  = '0;
            state_next.epoch_count   = state.epoch_count + TIME_W'(1);
            add_special              = 1'b1;
            stamp                    = TIME_ALL_ONES;
            result.event_kind        = KIND_WRAP;
            result.event_time        = TIME_ALL_ONES;
            forced                   = 1'b1;
         end else begin
            state_next.wrap_offset   = offset_inc;
            state_next.previous_time = state.current_time;
            state_next.current_time  = {offset_inc, {TICK_W{1'b0}}};
            result.time_backwards    = state_next.current_time < state.current_time;
         end
      end else if (time_word[14]) begin
         state_next.epoch_count   = '0;
         state_next.wrap_offset   = '0;
         state_next.previous_time = '0;
         state_next.current_time  = '0;
         add_special              = 1'b1;
         stamp                    = TIME_ALL_ONES;
         result.event_kind        = KIND_RESET;
         result.event_time        = TIME_ALL_ONES;
         forced                   = 1'b1;
      end else begin
         state_next.previous_time = state.current_time;
         state_next.current_time  = {state.wrap_offset, time_word[TICK_W-1:0]};
         result.time_backwards    = state_next.current_time < state.current_time;
         stamp                    = state_next.current_time;
         if (address_word[15]) begin
            add_special       = 1'b1;
            result.event_kind = KIND_TRIGGER;
            result.event_time = state_next.current_time;
         end else if (({1'b0, raw_x} > 8'(ARRAY_WIDTH - 1))
                      || ({1'b0, row_y} >= 8'(ARRAY_HEIGHT))) begin
            do_check = 1'b0;
         end else begin
            add_pixel         = 1'b1;
            result.event_kind = KIND_PIXEL;
            result.event_time = state_next.current_time;
            result.pixel_x    = COORD_W'(ARRAY_WIDTH - 1) - raw_x;
            result.pixel_y    = row_y;
            result.pixel_on   = ~address_word[0];
         end
      end

      if (add_pixel) begin
         if (state.pixel_count == '0) begin
            state_next.pixel_first_time = stamp;
         end
         state_next.pixel_last_time = stamp;
         if (state.pixel_count != COUNT_ALL_ONES) begin
            state_next.pixel_count = state.pixel_count + COUNT_W'(1);
         end
      end
      if (add_special) begin
         if (state.special_count == '0) begin
            state_next.special_first_time = stamp;
         end
         state_next.special_last_time = stamp;
         if (state.special_count != COUNT_ALL_ONES) begin
            state_next.special_count = state.special_count + COUNT_W'(1);
         end
      end

      // spans only count once a packet holds two events
      if (state_next.pixel_count > COUNT_W'(1)) begin
         pixel_span = $signed({1'b0, state_next.pixel_last_time})
                      - $signed({1'b0, state_next.pixel_first_time});
      end
      if (state_next.special_count > COUNT_W'(1)) begin
         special_span = $signed({1'b0, state_next.special_last_time})
                        - $signed({1'b0, state_next.special_first_time});
      end
      span_sum  = {pixel_span[TIME_W], pixel_span} + {special_span[TIME_W], special_span};
      count_sum = {1'b0, state_next.pixel_count} + {1'b0, state_next.special_count};

      container_hit = (count_sum >= {1'b0, cfg.container_max_events})
                      || (span_sum >= $signed({2'b00, cfg.container_max_interval}));
      pixel_hit     = (state_next.pixel_count >= cfg.pixel_max_events)
                      || (pixel_span >= $signed({1'b0, cfg.pixel_max_interval}));
      special_hit   = (state_next.special_count >= cfg.special_max_events)
                      || (special_span >= $signed({1'b0, cfg.special_max_interval}));

      if (do_check && (forced || container_hit || pixel_hit || special_hit)) begin
         result.commit            = 1'b1;
         result.pixel_committed   = state_next.pixel_count;
         result.special_committed = state_next.special_count;
         state_next.pixel_count   = '0;
         state_next.special_count = '0;
      end

      result.epoch = state_next.epoch_count;
   end

endmodule
